>>> hw/rtl/bpdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breath pressure deadband reporter package
// Shared widths, types and constants for the reporter and its checker.
// ----------------------------------------------------------------------------
package bpdr_pkg;

    // Converter words, the unpacked reading and the reported value.
    localparam int WordW  = 16;
    localparam int ValueW = 14;
    localparam int HalfW  = 7;

    typedef logic [WordW-1:0]  t_word;
    typedef logic [ValueW-1:0] t_value;
    typedef logic [HalfW-1:0]  t_half;

    // Reset value of the last reported values, which no 14-bit value equals.
    localparam t_word LastReset = 16'd65000;

    // Message channel codes.
    localparam logic SidePos = 1'b0;
    localparam logic SideNeg = 1'b1;

endpackage

>>> hw/rtl/breath_pressure_deadband_reporter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breath pressure deadband reporter
// Unpacks a pressure reading, captures a baseline after warm-up, and reports
// changes of the excess above or below a deadband around that baseline.
// ----------------------------------------------------------------------------
//  Channel  | Valid        | Stall        | Payload
//  ---------+--------------+--------------+----------------------------------
//  input    | i_in_valid   | o_in_stall   | i_first_word, i_second_word
//  output   | o_out_valid  | i_out_stall  | o_send_valid, o_side, o_value_high,
//           |              |              | o_value_low, o_led_level
//  config   | i_cfg_we     | (none)       | i_cfg_wdata
//
// One sample per cycle is sustained while the output is not stalled; a sample
// passes through the input register, then the result register, from which
// its result is offered.
// The warm-up count, baseline and last values update as a sample leaves the
// input register, so samples are processed strictly in order.
// Reset is synchronous and active low; it clears all control state.
// A stall on the output holds the result register and, once the input
// register is also full, stalls the input.
// ----------------------------------------------------------------------------
module breath_pressure_deadband_reporter_top #(
    parameter int WARMUP_SAMPLES = 100
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  bpdr_pkg::t_word      i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bpdr_pkg::t_word      i_first_word,
    input  bpdr_pkg::t_word      i_second_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_send_valid,
    output logic                 o_side,
    output bpdr_pkg::t_half      o_value_high,
    output bpdr_pkg::t_half      o_value_low,
    output bpdr_pkg::t_half      o_led_level
);
    import bpdr_pkg::*;

    localparam int CntW = $clog2(WARMUP_SAMPLES + 2);
    localparam logic [CntW-1:0] CntLimit = CntW'(WARMUP_SAMPLES);

    // Configuration register.
    t_word r_deadband;

    // Input register.
    logic  r_s1_vld;
    t_word r_w0;
    t_word r_w1;

    // Sample state.
    logic [CntW-1:0] r_count;
    t_word           r_baseline;
    t_word           r_last_pos;
    t_word           r_last_neg;

    // Result register.
    logic  r_out_vld;
    logic  r_send;
    logic  r_side;
    t_half r_vhigh;
    t_half r_vlow;
    t_half r_led;

    logic s2_load;
    logic s1_move;
    logic in_xfer;

    // Datapath signals.
    t_word            reading;
    t_word            base_eff;
    logic [WordW:0]   upper;
    logic [WordW:0]   low_sum;
    t_word            pos_full;
    t_word            neg_full;
    t_value           pos;
    t_value           neg;
    logic             n_send;
    logic             n_side;
    t_value           n_val;
    t_half            n_led;

    // Handshake: the result register frees when empty or being taken.
    assign s2_load    = !r_out_vld || !i_out_stall;
    assign s1_move    = r_s1_vld && s2_load;
    assign o_in_stall = r_s1_vld && !s2_load;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Reading unpack and the baseline seen by this sample.
    assign reading  = {r_w0[11:0], r_w1[15:12]};
    assign base_eff = (r_count == CntLimit) ? reading : r_baseline;

    // Deadband bounds at 17 bits: above when reading exceeds base plus width,
    // below when reading plus width is under the base.
    assign upper   = {1'b0, base_eff} + {1'b0, r_deadband};
    assign low_sum = {1'b0, reading} + {1'b0, r_deadband};

    always_comb begin
        pos_full = '0;
        neg_full = '0;
        if (low_sum < {1'b0, base_eff}) begin
            neg_full = base_eff - low_sum[WordW-1:0];
        end else if ({1'b0, reading} > upper) begin
            pos_full = reading - upper[WordW-1:0];
        end
    end

    assign pos = pos_full[WordW-1:2];
    assign neg = neg_full[WordW-1:2];

    // Change detection, positive side first.
    always_comb begin
        n_send = 1'b0;
        n_side = SidePos;
        n_val  = '0;
        if ({2'b00, pos} != r_last_pos) begin
            n_send = 1'b1;
            n_side = SidePos;
            n_val  = pos;
        end else if ({2'b00, neg} != r_last_neg) begin
            n_send = 1'b1;
            n_side = SideNeg;
            n_val  = neg;
        end
    end

    // LED level: the value divided by 128 is its top seven bits.
    assign n_led = (pos != '0) ? pos[ValueW-1:HalfW] : neg[ValueW-1:HalfW];

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= '0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_count    <= '0;
            r_baseline <= '0;
            r_last_pos <= LastReset;
            r_last_neg <= LastReset;
        end else begin
            if (i_cfg_we) begin
                r_deadband <= i_cfg_wdata;
            end
            if (in_xfer) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s2_load) begin
                r_out_vld <= r_s1_vld;
            end
            if (s1_move) begin
                if (r_count <= CntLimit) begin
                    r_count <= r_count + 1'b1;
                end
                r_baseline <= base_eff;
                if (n_send && n_side == SidePos) begin
                    r_last_pos <= {2'b00, pos};
                end
                if (n_send && n_side == SideNeg) begin
                    r_last_neg <= {2'b00, neg};
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_w0 <= i_first_word;
            r_w1 <= i_second_word;
        end
        if (s1_move) begin
            r_send  <= n_send;
            r_side  <= n_side;
            r_vhigh <= n_val[ValueW-1:HalfW];
            r_vlow  <= n_val[HalfW-1:0];
            r_led   <= n_led;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_send_valid = r_send;
    assign o_side       = r_side;
    assign o_value_high = r_vhigh;
    assign o_value_low  = r_vlow;
    assign o_led_level  = r_led;

endmodule

>>> hw/rtl/bpdr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breath pressure deadband reporter checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bpdr_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  logic                 o_send_valid,
    input  logic                 o_side,
    input  bpdr_pkg::t_half      o_value_high,
    input  bpdr_pkg::t_half      o_value_low,
    input  bpdr_pkg::t_half      o_led_level
);
    import bpdr_pkg::*;

    // A stalled result stays offered.
    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its payload.
    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_send_valid) && $stable(o_side) && $stable(o_value_high)
            && $stable(o_value_low) && $stable(o_led_level))
        else $error("result payload changed while stalled");

    // Without a message the message fields are zero.
    a_quiet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_send_valid |->
            o_side == SidePos && o_value_high == '0 && o_value_low == '0)
        else $error("message fields set without a message");

    // A positive message with a nonzero value drives the LED from the same value.
    a_pos_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_valid && o_side == SidePos |->
            (o_value_high == o_led_level)
            || (o_value_high == '0 && o_value_low == '0))
        else $error("LED level disagrees with positive message");

endmodule

bind breath_pressure_deadband_reporter_top bpdr_checker u_bpdr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_send_valid (o_send_valid),
    .o_side       (o_side),
    .o_value_high (o_value_high),
    .o_value_low  (o_value_low),
    .o_led_level  (o_led_level)
);

>>> sim/breath_pressure_deadband_reporter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breath pressure deadband reporter checker
// Watches the sample, result and configuration channels of the reporter.
// Keeps its own copy of the warm-up, baseline and last-value state, predicts
// the report for every sample transfer and compares each result transfer
// with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module breath_pressure_deadband_reporter_checker #(
    parameter int WARMUP_SAMPLES = 100
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  bpdr_pkg::t_word   i_cfg_wdata,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  bpdr_pkg::t_word   i_first_word,
    input  bpdr_pkg::t_word   i_second_word,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_send_valid,
    input  logic              i_side,
    input  bpdr_pkg::t_half   i_value_high,
    input  bpdr_pkg::t_half   i_value_low,
    input  bpdr_pkg::t_half   i_led_level,
    output int                o_fail_count,
    output int                o_pending
);

    import bpdr_pkg::*;

    // One predicted report.
    typedef struct packed {
        logic  send_valid;
        logic  side;
        t_half value_high;
        t_half value_low;
        t_half led_level;
    } t_report;

    // Predicted state and the copy of the deadband register.
    logic [6:0] warmup_seen;
    t_word      baseline;
    t_word      last_above;
    t_word      last_below;
    t_word      band_width;

    t_report    report_q[$];
    t_report    oldest;
    int         mismatches = 0;
    int         waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    // Works out the report of one sample and advances the predicted state.
    function automatic t_report predict_report(input t_word first_word,
                                               input t_word second_word);
        t_word               reading;
        logic signed [17:0]  lo_rim;
        logic signed [17:0]  hi_rim;
        logic signed [17:0]  level;
        logic [17:0]         excess;
        t_value              above;
        t_value              below;
        t_value              shown;
        t_report             rep;

        reading = {first_word[11:0], second_word[15:12]};

        // The sample after the warm-up count is complete becomes the baseline.
        if (warmup_seen < WARMUP_SAMPLES) begin
            warmup_seen = warmup_seen + 7'd1;
        end else if (warmup_seen == WARMUP_SAMPLES) begin
            baseline    = reading;
            warmup_seen = warmup_seen + 7'd1;
        end

        // The band edges are signed and wide enough that they never wrap.
        lo_rim = $signed({2'b00, baseline}) - $signed({2'b00, band_width});
        hi_rim = $signed({2'b00, baseline}) + $signed({2'b00, band_width});
        level  = $signed({2'b00, reading});
        above  = '0;
        below  = '0;
        if (level < lo_rim) begin
            excess = 18'(lo_rim - level);
            below  = excess[15:2];
        end else if (level > hi_rim) begin
            excess = 18'(level - hi_rim);
            above  = excess[15:2];
        end

        // A change on the positive side takes precedence over the negative.
        rep   = '0;
        shown = '0;
        if ({2'b00, above} != last_above) begin
            rep.send_valid = 1'b1;
            rep.side       = SidePos;
            shown          = above;
            last_above     = {2'b00, above};
        end else if ({2'b00, below} != last_below) begin
            rep.send_valid = 1'b1;
            rep.side       = SideNeg;
            shown          = below;
            last_below     = {2'b00, below};
        end
        rep.value_high = shown[13:7];
        rep.value_low  = shown[6:0];
        rep.led_level  = (above != '0) ? above[13:7] : below[13:7];
        return rep;
    endfunction

    task automatic check_field(input string field, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, got %0d", field, expected, actual);
            mismatches++;
        end
    endtask

    // Compare result transfers, predict sample transfers, track the register.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            warmup_seen = '0;
            baseline    = '0;
            last_above  = LastReset;
            last_below  = LastReset;
            band_width  = '0;
            report_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (report_q.size() == 0) begin
                    $error("result transfer with no prediction waiting");
                    mismatches++;
                end else begin
                    oldest = report_q.pop_front();
                    check_field("send_valid", oldest.send_valid, i_send_valid);
                    check_field("side", oldest.side, i_side);
                    check_field("value_high", oldest.value_high, i_value_high);
                    check_field("value_low", oldest.value_low, i_value_low);
                    check_field("led_level", oldest.led_level, i_led_level);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                report_q.push_back(predict_report(i_first_word, i_second_word));
            end
            if (i_cfg_we) begin
                band_width = i_cfg_wdata;
            end
        end
        waiting = report_q.size();
    end

endmodule

>>> sim/breath_pressure_deadband_reporter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breath pressure deadband reporter testbench
// Drives pressure samples and deadband settings into the reporter, with the
// checker beside it. A directed start covers word extremes, the warm-up with
// a zero baseline and bands past either end; random phases then exercise the
// band edges with several widths and several idle and stall patterns.
// ----------------------------------------------------------------------------
module breath_pressure_deadband_reporter_top_test;

    import bpdr_pkg::*;

    localparam int WarmupSamples = 100;
    localparam int PhaseItems    = 225;
    localparam int PhaseCount    = 8;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_word i_cfg_wdata;
    logic  i_in_valid;
    logic  o_in_stall;
    t_word i_first_word;
    t_word i_second_word;
    logic  o_out_valid;
    logic  i_out_stall;
    logic  o_send_valid;
    logic  o_side;
    t_half o_value_high;
    t_half o_value_low;
    t_half o_led_level;

    int    fail_count;
    int    pending_results;
    int    sender_idle_pct = 0;
    int    stall_pct = 0;
    bit    long_hold_req = 1'b0;
    int    samples_sent = 0;

    breath_pressure_deadband_reporter_top #(
        .WARMUP_SAMPLES(WarmupSamples)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_first_word  (i_first_word),
        .i_second_word (i_second_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_send_valid  (o_send_valid),
        .o_side        (o_side),
        .o_value_high  (o_value_high),
        .o_value_low   (o_value_low),
        .o_led_level   (o_led_level)
    );

    breath_pressure_deadband_reporter_checker #(
        .WARMUP_SAMPLES(WarmupSamples)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_first_word  (i_first_word),
        .i_second_word (i_second_word),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_send_valid  (o_send_valid),
        .i_side        (o_side),
        .i_value_high  (o_value_high),
        .i_value_low   (o_value_low),
        .i_led_level   (o_led_level),
        .o_fail_count  (fail_count),
        .o_pending     (pending_results)
    );

    // Clock with a 4 ns period.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("breath_pressure_deadband_reporter_top_test: FAIL");
        $finish;
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    initial begin : receiver
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Offers one sample, with random gaps first, and returns at the falling
    // edge after its transfer with valid still high.
    task automatic send_sample(input t_word first_word, input t_word second_word);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_first_word  <= first_word;
        i_second_word <= second_word;
        do @(posedge i_clk); while (o_in_stall);
        samples_sent++;
        @(negedge i_clk);
    endtask

    // Packs a reading into the two words, with random bits in the unused parts.
    task automatic send_reading(input t_word level);
        t_word spare;
        spare = t_word'($urandom);
        send_sample({spare[15:12], level[15:4]}, {level[3:0], spare[11:0]});
    endtask

    // Stops offering and waits until every predicted report has arrived.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_band_width(input t_word width);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= width;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Stimulus and verdict.
    initial begin : stimulus
        int    baseline_level;
        int    band_width;
        int    prev_level;
        int    level;
        int    rim;
        int    choice;
        t_word width;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_first_word  = '0;
        i_second_word = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Warm-up with a zero baseline and a zero band: word extremes, the
        // first reports on both sides, and the shift boundaries.
        write_band_width(16'd0);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hF000, 16'h0FFF);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'h0FFF, 16'hF000);
        send_reading(16'h0003);
        send_reading(16'h0004);
        send_reading(16'h0007);
        send_reading(16'h0200);
        send_reading(16'h01FC);
        send_reading(16'h8000);

        // Widest band: the lower edge is below zero, the upper at the top.
        write_band_width(16'hFFFF);
        send_reading(16'hFFFF);
        send_reading(16'h0000);
        send_reading(16'h8000);

        // Narrow band with its lower edge below zero.
        write_band_width(16'h0100);
        band_width = 16'h0100;
        send_reading(16'h0000);
        send_reading(16'h0104);
        send_reading(16'h0103);
        send_reading(16'hFFFF);

        // Rest of the warm-up, then the sample that becomes the baseline.
        sender_idle_pct = 61;
        while (samples_sent < WarmupSamples) begin
            send_sample(t_word'($urandom), t_word'($urandom));
        end
        baseline_level = int'($urandom_range(49151, 16384));
        send_reading(t_word'(baseline_level));

        // Readings on and just past both band edges.
        send_reading(t_word'(baseline_level + band_width));
        send_reading(t_word'(baseline_level + band_width + 3));
        send_reading(t_word'(baseline_level + band_width + 4));
        send_reading(t_word'(baseline_level - band_width));
        send_reading(t_word'(baseline_level - band_width - 4));
        send_reading(t_word'(baseline_level - band_width - 3));
        prev_level = baseline_level;

        // Random phases, each with its own band width and idle pattern.
        for (int phase = 0; phase < PhaseCount; phase++) begin
            case (phase)
                0:       width = 16'd0;
                1:       width = 16'hFFFF;
                2:       width = t_word'($urandom_range(65535));
                3:       width = t_word'($urandom_range(2047));
                4:       width = 16'd1;
                5:       width = t_word'($urandom_range(255));
                6:       width = t_word'($urandom_range(65535));
                default: width = 16'h4000;
            endcase
            write_band_width(width);
            band_width = width;

            case (phase % 4)
                0: begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                    long_hold_req   = 1'b1;
                end
                1: begin
                    sender_idle_pct = 61;
                    stall_pct       = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    stall_pct       = 61;
                end
                default: begin
                    sender_idle_pct = 6;
                    stall_pct       = 6;
                end
            endcase

            for (int item = 0; item < PhaseItems; item++) begin
                // Mid-phase pause until every report has come back.
                if (phase % 4 == 2 && item == PhaseItems / 2) begin
                    drain_results();
                end

                // Mostly repeats, in-band readings and readings near the edges.
                choice = $urandom_range(99);
                if (choice < 20) begin
                    level = prev_level;
                end else if (choice < 40) begin
                    level = baseline_level - band_width
                            + int'($urandom_range(2 * band_width));
                end else if (choice < 70) begin
                    rim   = $urandom_range(1) ? baseline_level + band_width
                                              : baseline_level - band_width;
                    level = rim + int'($urandom_range(80)) - 40;
                end else if (choice < 85) begin
                    level = prev_level + int'($urandom_range(1024)) - 512;
                end else begin
                    level = int'($urandom_range(65535));
                end
                if (level < 0) begin
                    level = 0;
                end
                if (level > 65535) begin
                    level = 65535;
                end
                prev_level = level;
                send_reading(t_word'(level));
            end
        end

        // Let every outstanding report arrive, then give the verdict.
        drain_results();
        if (fail_count == 0) begin
            $display("breath_pressure_deadband_reporter_top_test: PASS");
        end else begin
            $display("breath_pressure_deadband_reporter_top_test: FAIL");
        end
        $finish;
    end

endmodule

>>> breath_pressure_deadband_reporter_top.f
hw/rtl/bpdr_pkg.sv
hw/rtl/breath_pressure_deadband_reporter_top.sv
hw/rtl/bpdr_checker.sv
sim/breath_pressure_deadband_reporter_checker.sv
sim/breath_pressure_deadband_reporter_top_test.sv
